@@ design/circle_segment_collision_point_macros.svh @@
// ---------------------------------------------------------------------------
// Circle/segment collision point: assertion macros
// Shared concurrent assertion forms for the collision point design.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_SEGMENT_COLLISION_POINT_MACROS_SVH
`define CIRCLE_SEGMENT_COLLISION_POINT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CSCP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CSCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/cscp_pkg.sv @@
// ---------------------------------------------------------------------------
// Circle/segment collision point package
// Fixed widths and segment classification codes.
// ---------------------------------------------------------------------------
package cscp_pkg;

   // Radius field width, fixed by the interface.
   localparam int RADIUS_BITS = 11;

   // A hit keeps the perpendicular offset below the radius, so the quotient
   // magnitude needs no more bits than the radius does.
   localparam int QUO_BITS = RADIUS_BITS;

   localparam int KIND_BITS = 2;
   localparam logic [KIND_BITS-1:0] KIND_VERT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_HORZ = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_GEN  = 2'd2;

endpackage

@@ design/cscp_div.sv @@
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned division, one quotient bit per register stage, with stage enables.
// ---------------------------------------------------------------------------
module cscp_div #(
   parameter int NUM_W = 37,
   parameter int DEN_W = 25,
   parameter int QB    = 11
) (
   input  logic             clock,
   input  logic [QB-1:0]    en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QB-1:0]    quo
);

   localparam int CW = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1;

   logic [CW-1:0]    rem_ff [QB];
   logic [DEN_W-1:0] den_ff [QB];
   logic [QB-1:0]    quo_ff [QB];

   // The caller guarantees num < den * 2**QB whenever the quotient matters.
   for (genvar j = 0; j < QB; j++) begin : g_step
      logic [CW-1:0]    rem_prev;
      logic [CW-1:0]    trial;
      logic [DEN_W-1:0] den_prev;
      logic [QB-1:0]    quo_prev;
      logic             fits;

      if (j == 0) begin : g_first
         assign rem_prev = CW'(num);
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      assign trial = CW'(den_prev) << (QB - 1 - j);
      assign fits  = (rem_prev >= trial);

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j] <= fits ? (rem_prev - trial) : rem_prev;
            den_ff[j] <= den_prev;
            quo_ff[j] <= quo_prev | (QB'(fits) << (QB - 1 - j));
         end
      end
   end

   assign quo = quo_ff[QB-1];

endmodule

@@ design/circle_segment_collision_point.sv @@
// Throughput: one transaction per cycle unless the response stalls; the
// restoring divider gives one quotient bit per stage, which sets most of
// the pipeline depth. A stalled response holds the pipeline; empty stages
// still fill behind it. Reset is synchronous and active high; it clears
// all stage valid bits and holds req_tready low.
// ---------------------------------------------------------------------------
// Circle/segment collision point
// Reports whether a segment meets a circle and where, as a deep pipeline.
// ---------------------------------------------------------------------------
`include "circle_segment_collision_point_macros.svh"

module circle_segment_collision_point #(
   parameter int COORD_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // center_x, center_y, radius, start_x, start_y, end_x, end_y, zero pad
   input  logic [((6*COORD_BITS+cscp_pkg::RADIUS_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit, contact_x, contact_y, zero pad
   output logic [((2*COORD_BITS+3+7)/8)*8-1:0] rsp_tdata
);

   import cscp_pkg::*;

   localparam int RSP_W = ((2*COORD_BITS + 3 + 7) / 8) * 8;
   localparam int OUT_BITS = COORD_BITS + 1;
   // Relative coordinates and differences.
   localparam int AW   = COORD_BITS + 1;
   // Products of two relative values, and the cross product.
   localparam int DW   = 2 * AW;
   // Squared segment length and cross product magnitude.
   localparam int LW   = 2 * AW - 1;
   localparam int DMW  = 2 * AW - 1;
   localparam int DL   = DMW / 2;
   localparam int DH   = DMW - DL;
   localparam int LL   = LW / 2;
   localparam int LH   = LW - LL;
   localparam int RRW  = 2 * RADIUS_BITS;
   localparam int CMW  = ((2*DMW > RRW + LW) ? 2*DMW : RRW + LW) + 1;
   // Signed numerator of the foot point offset and its magnitude.
   localparam int NPW  = DW + AW;
   localparam int NW   = 3 * COORD_BITS + 1;
   localparam int EW   = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
   localparam int PW   = ((COORD_BITS > QUO_BITS + 1) ? COORD_BITS : QUO_BITS + 1) + 1;
   localparam int DIV0 = 7;
   localparam int NS   = DIV0 + QUO_BITS + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] sx;
      logic signed [COORD_BITS-1:0] sy;
      logic signed [COORD_BITS-1:0] ex;
      logic signed [COORD_BITS-1:0] ey;
      logic [RADIUS_BITS-1:0]       r;
      logic [KIND_BITS-1:0]         kind;
      logic                         axis_hit;
      logic signed [OUT_BITS-1:0]   axis_x;
      logic signed [OUT_BITS-1:0]   axis_y;
      logic signed [AW-1:0]         ax;
      logic signed [AW-1:0]         ay;
      logic signed [AW-1:0]         bx;
      logic signed [AW-1:0]         by;
      logic signed [AW-1:0]         dx;
      logic signed [AW-1:0]         dy;
      logic signed [DW-1:0]         p1;
      logic signed [DW-1:0]         p2;
      logic signed [DW-1:0]         xx;
      logic signed [DW-1:0]         yy;
      logic signed [DW-1:0]         d;
      logic [RRW-1:0]               rr;
      logic [LW-1:0]                len2;
      logic [DMW-1:0]               dm;
      logic [RRW+LL-1:0]            rlo;
      logic [RRW+LH-1:0]            rhi;
      logic signed [NPW-1:0]        nx;
      logic signed [NPW-1:0]        ny;
      logic [2*DH-1:0]              hh;
      logic [DH+DL-1:0]             hl;
      logic [2*DL-1:0]              ll;
      logic [CMW-1:0]               rl;
      logic [CMW-1:0]               dd;
      logic [NW-1:0]                nxm;
      logic [NW-1:0]                nym;
      logic                         nx_neg;
      logic                         ny_neg;
      logic                         disc_pos;
   } pipe_type;

   pipe_type              pipe_ff [NS-1];
   pipe_type              pipe_in [NS-1];
   logic [NS-1:0]         valid_ff;
   logic [NS-1:0]         en;
   logic [QUO_BITS-1:0]   qx;
   logic [QUO_BITS-1:0]   qy;
   logic                  hit_ff;
   logic signed [OUT_BITS-1:0] contact_x_ff;
   logic signed [OUT_BITS-1:0] contact_y_ff;
   logic                  hit_in;
   logic signed [OUT_BITS-1:0] contact_x_in;
   logic signed [OUT_BITS-1:0] contact_y_in;
   logic                  in_acc;
   logic                  out_acc;

   // A stage loads whenever it is empty or the stage after it moves, so
   // bubbles close up behind a stalled response.
   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[0] && !reset;
   assign in_acc     = req_tvalid && req_tready;
   assign out_acc    = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // Stage logic. Each stage passes the record on and fills in its own fields.
   always_comb begin
      logic signed [EW-1:0] lo_x;
      logic signed [EW-1:0] hi_x;
      logic signed [EW-1:0] lo_y;
      logic signed [EW-1:0] hi_y;
      logic                 vert_in;
      logic                 horz_in;

      pipe_in[0]    = '0;
      pipe_in[0].cx = req_tdata[COORD_BITS-1:0];
      pipe_in[0].cy = req_tdata[2*COORD_BITS-1:COORD_BITS];
      pipe_in[0].r  = req_tdata[2*COORD_BITS +: RADIUS_BITS];
      pipe_in[0].sx = req_tdata[2*COORD_BITS+RADIUS_BITS +: COORD_BITS];
      pipe_in[0].sy = req_tdata[3*COORD_BITS+RADIUS_BITS +: COORD_BITS];
      pipe_in[0].ex = req_tdata[4*COORD_BITS+RADIUS_BITS +: COORD_BITS];
      pipe_in[0].ey = req_tdata[5*COORD_BITS+RADIUS_BITS +: COORD_BITS];

      for (int k = 1; k < NS - 1; k++) begin
         pipe_in[k] = pipe_ff[k-1];
      end

      // Stage 1: relative end points, segment kind and the axis tests.
      pipe_in[1].ax = AW'(pipe_ff[0].sx) - AW'(pipe_ff[0].cx);
      pipe_in[1].ay = AW'(pipe_ff[0].sy) - AW'(pipe_ff[0].cy);
      pipe_in[1].bx = AW'(pipe_ff[0].ex) - AW'(pipe_ff[0].cx);
      pipe_in[1].by = AW'(pipe_ff[0].ey) - AW'(pipe_ff[0].cy);
      pipe_in[1].dx = AW'(pipe_ff[0].ex) - AW'(pipe_ff[0].sx);
      pipe_in[1].dy = AW'(pipe_ff[0].ey) - AW'(pipe_ff[0].sy);
      lo_x = EW'(pipe_ff[0].cx) - EW'($signed({1'b0, pipe_ff[0].r}));
      hi_x = EW'(pipe_ff[0].cx) + EW'($signed({1'b0, pipe_ff[0].r}));
      lo_y = EW'(pipe_ff[0].cy) - EW'($signed({1'b0, pipe_ff[0].r}));
      hi_y = EW'(pipe_ff[0].cy) + EW'($signed({1'b0, pipe_ff[0].r}));
      vert_in = (lo_x <= EW'(pipe_ff[0].sx)) && (EW'(pipe_ff[0].sx) <= hi_x);
      horz_in = (lo_y <= EW'(pipe_ff[0].sy)) && (EW'(pipe_ff[0].sy) <= hi_y);
      // A segment with equal end points falls under the vertical rule.
      if (pipe_ff[0].sx == pipe_ff[0].ex) begin
         pipe_in[1].kind     = KIND_VERT;
         pipe_in[1].axis_hit = vert_in;
         pipe_in[1].axis_x   = vert_in ? OUT_BITS'(pipe_ff[0].sx) : '0;
         pipe_in[1].axis_y   = vert_in ? OUT_BITS'(pipe_ff[0].cy) : '0;
      end else if (pipe_ff[0].sy == pipe_ff[0].ey) begin
         pipe_in[1].kind     = KIND_HORZ;
         pipe_in[1].axis_hit = horz_in;
         pipe_in[1].axis_x   = horz_in ? OUT_BITS'(pipe_ff[0].cx) : '0;
         pipe_in[1].axis_y   = horz_in ? OUT_BITS'(pipe_ff[0].sy) : '0;
      end else begin
         pipe_in[1].kind     = KIND_GEN;
         pipe_in[1].axis_hit = 1'b0;
         pipe_in[1].axis_x   = '0;
         pipe_in[1].axis_y   = '0;
      end

      // Stage 2: the cross product terms and squares.
      pipe_in[2].p1 = pipe_ff[1].ax * pipe_ff[1].by;
      pipe_in[2].p2 = pipe_ff[1].bx * pipe_ff[1].ay;
      pipe_in[2].xx = pipe_ff[1].dx * pipe_ff[1].dx;
      pipe_in[2].yy = pipe_ff[1].dy * pipe_ff[1].dy;
      pipe_in[2].rr = pipe_ff[1].r * pipe_ff[1].r;

      // Stage 3: cross product and squared length.
      pipe_in[3].d    = pipe_ff[2].p1 - pipe_ff[2].p2;
      pipe_in[3].len2 = LW'($unsigned(pipe_ff[2].xx + pipe_ff[2].yy));

      // Stage 4: cross product magnitude, the radius term in two halves and
      // the numerators of the foot point offsets.
      pipe_in[4].dm  = (pipe_ff[3].d < 0) ? DMW'($unsigned(-pipe_ff[3].d))
                                          : DMW'($unsigned(pipe_ff[3].d));
      pipe_in[4].rlo = pipe_ff[3].rr * pipe_ff[3].len2[LL-1:0];
      pipe_in[4].rhi = pipe_ff[3].rr * pipe_ff[3].len2[LW-1:LL];
      pipe_in[4].nx  = pipe_ff[3].d * pipe_ff[3].dy;
      pipe_in[4].ny  = pipe_ff[3].d * pipe_ff[3].dx;

      // Stage 5: squared cross product in partial products, radius term; numerator signs.
      pipe_in[5].hh = pipe_ff[4].dm[DMW-1:DL] * pipe_ff[4].dm[DMW-1:DL];
      pipe_in[5].hl = pipe_ff[4].dm[DMW-1:DL] * pipe_ff[4].dm[DL-1:0];
      pipe_in[5].ll = pipe_ff[4].dm[DL-1:0] * pipe_ff[4].dm[DL-1:0];
      pipe_in[5].rl = (CMW'(pipe_ff[4].rhi) << LL) + CMW'(pipe_ff[4].rlo);
      pipe_in[5].nx_neg = (pipe_ff[4].nx < 0);
      pipe_in[5].nxm    = (pipe_ff[4].nx < 0) ? NW'($unsigned(-pipe_ff[4].nx))
                                              : NW'($unsigned(pipe_ff[4].nx));
      // The y offset uses the negated product.
      pipe_in[5].ny_neg = (pipe_ff[4].ny > 0);
      pipe_in[5].nym    = (pipe_ff[4].ny < 0) ? NW'($unsigned(-pipe_ff[4].ny))
                                              : NW'($unsigned(pipe_ff[4].ny));

      // Stage 6: sum of the partial products.
      pipe_in[6].dd = (CMW'(pipe_ff[5].hh) << (2*DL))
                    + (CMW'(pipe_ff[5].hl) << (DL + 1))
                    + CMW'(pipe_ff[5].ll);

      // Stage 7: discriminant sign; a tangent counts as a miss.
      pipe_in[DIV0].disc_pos = (pipe_ff[DIV0-1].rl > pipe_ff[DIV0-1].dd);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS - 1; k++) begin
         if (en[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // Two dividers share the squared length and run alongside the record.
   cscp_div #(
      .NUM_W(NW),
      .DEN_W(LW),
      .QB   (QUO_BITS)
   ) u_div_x (
      .clock(clock),
      .en   (en[DIV0 +: QUO_BITS]),
      .num  (pipe_ff[DIV0-1].nxm),
      .den  (pipe_ff[DIV0-1].len2),
      .quo  (qx)
   );

   cscp_div #(
      .NUM_W(NW),
      .DEN_W(LW),
      .QB   (QUO_BITS)
   ) u_div_y (
      .clock(clock),
      .en   (en[DIV0 +: QUO_BITS]),
      .num  (pipe_ff[DIV0-1].nym),
      .den  (pipe_ff[DIV0-1].len2),
      .quo  (qy)
   );

   // Output stage: foot point, range test on x and the final selection.
   always_comb begin
      logic signed [QUO_BITS:0] sqx;
      logic signed [QUO_BITS:0] sqy;
      logic signed [PW-1:0]     px;
      logic signed [PW-1:0]     py;
      logic                     in_range;

      sqx = pipe_ff[NS-2].nx_neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      sqy = pipe_ff[NS-2].ny_neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      px  = PW'(pipe_ff[NS-2].cx) + PW'(sqx);
      py  = PW'(pipe_ff[NS-2].cy) + PW'(sqy);
      in_range = (PW'(pipe_ff[NS-2].sx) <= px) && (px <= PW'(pipe_ff[NS-2].ex));

      if (pipe_ff[NS-2].kind != KIND_GEN) begin
         hit_in       = pipe_ff[NS-2].axis_hit;
         contact_x_in = pipe_ff[NS-2].axis_x;
         contact_y_in = pipe_ff[NS-2].axis_y;
      end else if (pipe_ff[NS-2].disc_pos) begin
         // The point is reported even when it lies outside the segment.
         hit_in       = in_range;
         contact_x_in = OUT_BITS'(px);
         contact_y_in = OUT_BITS'(py);
      end else begin
         hit_in       = 1'b0;
         contact_x_in = '0;
         contact_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         hit_ff       <= hit_in;
         contact_x_ff <= contact_x_in;
         contact_y_ff <= contact_y_in;
      end
   end

   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tdata  = RSP_W'({contact_y_ff, contact_x_ff, hit_ff});

   // Items in flight change only by what enters and what leaves.
   `CSCP_ASSERT_IMPL(a_inflight_count, clock, reset, !$past(reset),
      $countones(valid_ff) == $past($countones(valid_ff)) + int'($past(in_acc))
      - int'($past(out_acc)), "pipeline lost or duplicated a transaction")

   // The request side only stalls when every stage holds an item.
   `CSCP_ASSERT_IMPL(a_stall_full, clock, reset, !req_tready, &valid_ff,
      "request stalled while the pipeline had a bubble")

   // An accepted request occupies the first stage on the next cycle.
   `CSCP_ASSERT_NEXT(a_accept_lands, clock, reset, in_acc, valid_ff[0],
      "accepted request did not enter the pipeline")

endmodule
